// File: design/tmp_pkg.sv
// ============================================================================
// Trapezoidal motion profile package
// Shared types, register index codes and widths for the profile generator.
// ============================================================================
package tmp_pkg;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROFILE_MODE   = 3'd0,
        CFG_ACCEL_STEP     = 3'd1,
        CFG_ACCEL_SHIFT    = 3'd2,
        CFG_VELOCITY_LIMIT = 3'd3,
        CFG_VELOCITY_SHIFT = 3'd4
    } t_cfg_idx;

    // Profile modes.
    localparam logic MODE_JOG      = 1'b0;
    localparam logic MODE_POSITION = 1'b1;

    // Register file contents.
    typedef struct packed {
        logic        profile_mode;
        logic [14:0] accel_step;
        logic [4:0]  accel_shift;
        logic [14:0] velocity_limit;
        logic [3:0]  velocity_shift;
    } t_cfg;

    // One input beat.
    typedef struct packed {
        logic               enable;
        logic               start_req;
        logic signed [31:0] target_position;
        logic signed [15:0] commanded_velocity;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] position_out;
        logic signed [15:0] velocity_out;
        logic               busy_out;
        logic               done_out;
        logic               active_out;
    } t_out_item;

    // Generator state carried from tick to tick.
    typedef struct packed {
        logic [31:0] vel_acc;
        logic [31:0] position;
        logic [31:0] half_distance;
        logic [31:0] cruise_count;
        logic        execute_flag;
        logic        busy_flag;
        logic        done_flag;
        logic        negative_move;
        logic        second_half;
    } t_state;

endpackage

// File: design/tmp_channels.sv
// ============================================================================
// Trapezoidal motion profile channels
// Valid/ready channel interfaces for input beats, result beats and
// configuration writes.
// ============================================================================

// Input beat channel.
interface tmp_in_if import tmp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result beat channel.
interface tmp_out_if import tmp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface tmp_cfg_if import tmp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/tmp_cfg_regs.sv
// ============================================================================
// Trapezoidal motion profile configuration registers
// Decodes configuration write beats into the register file.
// ============================================================================
module tmp_cfg_regs import tmp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tmp_cfg_if.sink i_cfg,
    output t_cfg  o_cfg
);

    t_cfg r_cfg;

    // The user must issue writes only while the generator is idle; the block does not enforce it and is always ready.
    assign i_cfg.ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PROFILE_MODE:   r_cfg.profile_mode   <= i_cfg.data[0];
                CFG_ACCEL_STEP:     r_cfg.accel_step     <= i_cfg.data[14:0];
                CFG_ACCEL_SHIFT:    r_cfg.accel_shift    <= i_cfg.data[4:0];
                CFG_VELOCITY_LIMIT: r_cfg.velocity_limit <= i_cfg.data[14:0];
                CFG_VELOCITY_SHIFT: r_cfg.velocity_shift <= i_cfg.data[3:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/tmp_tick.sv
// ============================================================================
// Trapezoidal motion profile tick
// Combinational next-state logic for one control tick in jog or position mode.
// ============================================================================
module tmp_tick import tmp_pkg::*; (
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    // Position increment: velocity word shifted right arithmetically.
    function automatic logic [31:0] f_incr(input logic [31:0] acc, input logic [3:0] sh);
        logic signed [15:0] w;
        w = acc[31:16];
        w = w >>> sh;
        return {{16{w[15]}}, w};
    endfunction

    logic [31:0]        step;
    logic [31:0]        acc_up;
    logic [31:0]        acc_dn;
    logic signed [16:0] vw_now;
    logic signed [16:0] vw_up;
    logic signed [16:0] vw_dn;
    logic signed [16:0] vcom;
    logic signed [16:0] lim;
    logic signed [16:0] neg_lim;

    // Ramp step and the accumulator moved up or down by it.
    assign step    = {17'd0, i_cfg.accel_step} << i_cfg.accel_shift;
    assign acc_up  = i_state.vel_acc + step;
    assign acc_dn  = i_state.vel_acc - step;
    assign vw_now  = $signed({i_state.vel_acc[31], i_state.vel_acc[31:16]});
    assign vw_up   = $signed({acc_up[31], acc_up[31:16]});
    assign vw_dn   = $signed({acc_dn[31], acc_dn[31:16]});
    assign vcom    = $signed({i_item.commanded_velocity[15], i_item.commanded_velocity});
    assign lim     = $signed({2'b00, i_cfg.velocity_limit});
    assign neg_lim = -lim;

    // Jog ramp toward the command, clamped to the command and to the limit.
    logic [15:0] jog_vw;
    logic [31:0] jog_acc;

    always_comb begin
        jog_vw  = i_state.vel_acc[31:16];
        jog_acc = i_state.vel_acc;
        if (vw_now < vcom) begin
            jog_vw = acc_up[31:16];
            if (vw_up > vcom) jog_vw = vcom[15:0];
            if ($signed({jog_vw[15], jog_vw}) > lim) jog_vw = lim[15:0];
            jog_acc = {jog_vw, acc_up[15:0]};
        end else if (vw_now > vcom) begin
            jog_vw = acc_dn[31:16];
            if (vw_dn < vcom) jog_vw = vcom[15:0];
            if (-$signed({jog_vw[15], jog_vw}) > lim) jog_vw = neg_lim[15:0];
            jog_acc = {jog_vw, acc_dn[15:0]};
        end
    end

    // Move start: half of the signed distance, as magnitude and direction.
    logic [31:0]        diff;
    logic signed [31:0] half_s;
    assign diff   = i_item.target_position - i_state.position;
    assign half_s = $signed(diff) >>> 1;

    // First half: accelerate to the limit or count a cruise tick.
    logic        fh_accel;
    logic [31:0] fh_acc;
    logic [31:0] fh_inc;
    logic [31:0] fh_half;

    assign fh_accel = vw_now < lim;
    always_comb begin
        fh_acc = i_state.vel_acc;
        if (fh_accel) begin
            fh_acc = acc_up;
            if (vw_up > lim) fh_acc = {lim[15:0], acc_up[15:0]};
        end
    end
    assign fh_inc  = f_incr(fh_acc, i_cfg.velocity_shift);
    assign fh_half = i_state.half_distance - fh_inc;

    // Second half: burn the cruise count, then decelerate, then finish.
    logic        sh_cruise;
    logic        sh_decel;
    logic        sh_finish;
    logic [31:0] sh_acc;
    logic [31:0] sh_inc;
    logic [31:0] sh_base;

    assign sh_cruise = i_state.cruise_count != '0;
    assign sh_decel  = !sh_cruise && (i_state.vel_acc != '0);
    assign sh_finish = !sh_cruise && !sh_decel;
    assign sh_acc    = sh_decel ? (acc_dn[31] ? 32'd0 : acc_dn) : i_state.vel_acc;
    assign sh_inc    = f_incr(sh_acc, i_cfg.velocity_shift);
    assign sh_base   = sh_finish ? i_item.target_position : i_state.position;

    // Next state for the tick.
    t_state n_state;

    always_comb begin
        n_state              = i_state;
        n_state.execute_flag = i_state.execute_flag | i_item.start_req;
        if (i_cfg.profile_mode == MODE_JOG) begin
            if (!i_item.enable) begin
                n_state.vel_acc = '0;
            end else begin
                n_state.vel_acc  = jog_acc;
                n_state.position = i_state.position + f_incr(jog_acc, i_cfg.velocity_shift);
            end
        end else if (i_item.enable) begin
            if (!(n_state.execute_flag && !i_state.done_flag)) begin
                n_state.busy_flag = 1'b0;
                n_state.done_flag = 1'b0;
            end else if (!i_state.busy_flag) begin
                n_state.negative_move = half_s[31];
                n_state.half_distance = half_s[31] ? 32'(-half_s) : 32'(half_s);
                n_state.vel_acc       = '0;
                n_state.cruise_count  = '0;
                n_state.second_half   = 1'b0;
                n_state.busy_flag     = 1'b1;
            end else if (!i_state.second_half) begin
                n_state.vel_acc       = fh_acc;
                n_state.cruise_count  = fh_accel ? i_state.cruise_count
                                                 : i_state.cruise_count + 32'd1;
                n_state.half_distance = fh_half;
                n_state.position      = i_state.negative_move ? i_state.position - fh_inc
                                                              : i_state.position + fh_inc;
                if ($signed(fh_half) <= 0) n_state.second_half = 1'b1;
            end else begin
                n_state.vel_acc      = sh_acc;
                n_state.cruise_count = sh_cruise ? i_state.cruise_count - 32'd1
                                                 : i_state.cruise_count;
                if (sh_finish) begin
                    n_state.done_flag    = 1'b1;
                    n_state.execute_flag = 1'b0;
                end
                n_state.position = i_state.negative_move ? sh_base - sh_inc
                                                         : sh_base + sh_inc;
            end
        end
    end

    // Result fields follow the state after the tick; active follows the beat's enable.
    assign o_state               = n_state;
    assign o_result.position_out = n_state.position;
    assign o_result.velocity_out = n_state.vel_acc[31:16];
    assign o_result.busy_out     = n_state.busy_flag;
    assign o_result.done_out     = n_state.done_flag;
    assign o_result.active_out   = i_item.enable;

endmodule

// File: design/trapezoidal_motion_profile.sv
// ============================================================================
// Trapezoidal motion profile generator
// Per-tick velocity ramp (jog) and symmetric trapezoidal move (position)
// with an input register, one tick of logic and a result register.
//
//   Channel   Port    Direction   Payload
//   -------   -----   ---------   ----------------------------------------
//   input     i_in    sink        enable, start_req, target, velocity cmd
//   result    o_out   source      position, velocity, busy, done, active
//   config    i_cfg   sink        register index, write data
//
// One input beat is taken per cycle while i_in.ready is high; its result beat
// passes through the input register and then the result register.
// Reset clears the generator state, the register file and both valid flags.
// A stalled result holds the result register; the input register still takes
// one more beat, and i_in.ready drops only when both stages are full.
// ============================================================================
module trapezoidal_motion_profile import tmp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmp_in_if.sink    i_in,
    tmp_out_if.source o_out,
    tmp_cfg_if.sink   i_cfg
);

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_result;
    t_in_item  r_in_item;
    t_out_item r_out_item;
    logic      r_in_valid;
    logic      r_out_valid;
    logic      advance;

    // Register file.
    tmp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Tick logic between the input register and the result register.
    tmp_tick u_tick (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // A held beat moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // Generator state advances once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // A finished move is always still marked busy.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.done_flag |-> r_state.busy_flag)
        else $error("done flag set without busy flag");

    // Completing a move drops the execute request.
    a_done_clears_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state.done_flag) |-> !r_state.execute_flag)
        else $error("execute flag still set after move completion");

    // State changes only on a processed tick.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("generator state changed without a tick");

    // An untaken result is never dropped.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("pending result beat lost");

endmodule

// File: dv/tmp_checker.sv
// ============================================================================
// Trapezoidal motion profile checker
// Watches the input, result and configuration channels, predicts each result
// beat from its own copy of the generator state and registers, and compares
// the results field by field in order.
// ============================================================================
module tmp_checker import tmp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tmp_in_if    in_mon,
    tmp_out_if   out_mon,
    tmp_cfg_if   cfg_mon,
    input  logic i_wrap_up,
    output int   o_fail_count
);

    t_cfg      regs;
    t_state    motion;
    t_out_item predicted_ticks[$];
    int        results_seen;

    // Signed high half of the velocity accumulator.
    function automatic int speed_word();
        return int'($signed(motion.vel_acc[31:16]));
    endfunction

    function automatic void set_speed_word(input int v);
        motion.vel_acc[31:16] = v[15:0];
    endfunction

    // Position increment: velocity word shifted right arithmetically.
    function automatic logic [31:0] travel_step();
        int vw;
        vw = speed_word();
        return 32'(vw >>> regs.velocity_shift);
    endfunction

    function automatic void shift_position();
        if (motion.negative_move) begin
            motion.position = motion.position - travel_step();
        end else begin
            motion.position = motion.position + travel_step();
        end
    endfunction

    // One control tick of the generator.
    task automatic advance_tick(input t_in_item beat, output t_out_item res);
        int                 lim;
        int                 vcom;
        int                 half;
        logic [31:0]        step;
        logic signed [31:0] span;
        lim  = int'(regs.velocity_limit);
        vcom = int'(beat.commanded_velocity);
        step = 32'(regs.accel_step) << regs.accel_shift;
        if (beat.start_req) begin
            motion.execute_flag = 1'b1;
        end

        if (regs.profile_mode == MODE_JOG) begin
            // Jog: ramp toward the command, clamp to command and limit.
            if (!beat.enable) begin
                motion.vel_acc = '0;
            end else begin
                if (speed_word() < vcom) begin
                    motion.vel_acc = motion.vel_acc + step;
                    if (speed_word() > vcom) set_speed_word(vcom);
                    if (speed_word() > lim) set_speed_word(lim);
                end else if (speed_word() > vcom) begin
                    motion.vel_acc = motion.vel_acc - step;
                    if (speed_word() < vcom) set_speed_word(vcom);
                    if (-speed_word() > lim) set_speed_word(-lim);
                end
                motion.position = motion.position + travel_step();
            end
        end else if (beat.enable) begin
            if (!(motion.execute_flag && !motion.done_flag)) begin
                // Idle or finished: clear the status flags.
                motion.busy_flag = 1'b0;
                motion.done_flag = 1'b0;
            end else if (!motion.busy_flag) begin
                // Move start: half distance and direction, position held.
                span = beat.target_position - motion.position;
                half = span >>> 1;
                if (half < 0) begin
                    half = -half;
                    motion.negative_move = 1'b1;
                end else begin
                    motion.negative_move = 1'b0;
                end
                motion.half_distance = 32'(half);
                motion.vel_acc       = '0;
                motion.cruise_count  = '0;
                motion.second_half   = 1'b0;
                motion.busy_flag     = 1'b1;
            end else if (!motion.second_half) begin
                // First half: accelerate to the limit, then count cruise ticks.
                if (speed_word() < lim) begin
                    motion.vel_acc = motion.vel_acc + step;
                    if (speed_word() > lim) set_speed_word(lim);
                end else begin
                    motion.cruise_count = motion.cruise_count + 1;
                end
                motion.half_distance = motion.half_distance - travel_step();
                shift_position();
                if ($signed(motion.half_distance) <= 0) begin
                    motion.second_half = 1'b1;
                end
            end else begin
                // Second half: cruise out the count, decelerate, then snap.
                if (motion.cruise_count != 0) begin
                    motion.cruise_count = motion.cruise_count - 1;
                end else if (motion.vel_acc != 0) begin
                    motion.vel_acc = motion.vel_acc - step;
                    if (speed_word() < 0) motion.vel_acc = '0;
                end else begin
                    motion.done_flag    = 1'b1;
                    motion.execute_flag = 1'b0;
                    motion.position     = beat.target_position;
                end
                shift_position();
            end
        end

        res.position_out = motion.position;
        res.velocity_out = motion.vel_acc[31:16];
        res.busy_out     = motion.busy_flag;
        res.done_out     = motion.done_flag;
        res.active_out   = beat.enable;
    endtask

    task automatic report(input string field, input longint got_v, input longint want_v);
        $display("tmp_checker: result beat %0d, %s: got %0d, expected %0d",
                 results_seen, field, got_v, want_v);
        o_fail_count++;
    endtask

    // Register writes, result comparison and prediction, all at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            regs   = '0;
            motion = '0;
            predicted_ticks.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (t_cfg_idx'(cfg_mon.index))
                    CFG_PROFILE_MODE:   regs.profile_mode   = cfg_mon.data[0];
                    CFG_ACCEL_STEP:     regs.accel_step     = cfg_mon.data[14:0];
                    CFG_ACCEL_SHIFT:    regs.accel_shift    = cfg_mon.data[4:0];
                    CFG_VELOCITY_LIMIT: regs.velocity_limit = cfg_mon.data[14:0];
                    CFG_VELOCITY_SHIFT: regs.velocity_shift = cfg_mon.data[3:0];
                    default: ;
                endcase
            end

            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (predicted_ticks.size() == 0) begin
                    report("beat with nothing pending, position", longint'(got.position_out), 0);
                end else begin
                    want = predicted_ticks.pop_front();
                    if (got.position_out !== want.position_out) begin
                        report("position", longint'(got.position_out),
                               longint'(want.position_out));
                    end
                    if (got.velocity_out !== want.velocity_out) begin
                        report("velocity", longint'(got.velocity_out),
                               longint'(want.velocity_out));
                    end
                    if (got.busy_out !== want.busy_out) begin
                        report("busy", longint'(got.busy_out), longint'(want.busy_out));
                    end
                    if (got.done_out !== want.done_out) begin
                        report("done", longint'(got.done_out), longint'(want.done_out));
                    end
                    if (got.active_out !== want.active_out) begin
                        report("active", longint'(got.active_out), longint'(want.active_out));
                    end
                end
                results_seen++;
            end

            if (in_mon.valid && in_mon.ready) begin
                advance_tick(in_mon.data, want);
                predicted_ticks.push_back(want);
            end

            // At the end of the run nothing may still be pending.
            if (i_wrap_up && predicted_ticks.size() != 0) begin
                report("beats never delivered", longint'(predicted_ticks.size()), 0);
                predicted_ticks.delete();
            end
        end
    end

endmodule

// File: dv/tb.sv
// ============================================================================
// Trapezoidal motion profile testbench
// Drives directed and random control ticks in jog and position phases, with
// random gaps and stalls on both channels, and reports the checker's verdict.
// ============================================================================
module tb;
    import tmp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_TICKS = 500;
    localparam int MOVE_TICKS   = 36;
    localparam int LONG_HOLD    = 48;
    localparam int DRAIN_TAIL   = 4;
    localparam int CYCLE_LIMIT  = 250000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        wrap_up = 1'b0;
    int          fail_count;
    int          ticks_sent;
    int          ticks_seen;
    int          cycle_count;
    int          hold_asks;
    int          holds_served;
    int          sink_wait;
    int          sink_gap;
    bit          quiet;
    logic [31:0] last_position;

    tmp_in_if  in_ch();
    tmp_out_if out_ch();
    tmp_cfg_if cfg_ch();

    trapezoidal_motion_profile i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    tmp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_mon     (cfg_ch),
        .i_wrap_up   (wrap_up),
        .o_fail_count(fail_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Register value with its extremes weighted up.
    function automatic int pick_field(input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return hi;
        return $urandom_range(0, hi);
    endfunction

    // Beat counters, last delivered position and the run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (in_ch.valid && in_ch.ready) ticks_sent <= ticks_sent + 1;
        if (out_ch.valid && out_ch.ready) begin
            ticks_seen    <= ticks_seen + 1;
            last_position <= out_ch.data.position_out;
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            out_ch.ready <= 1'b0;
            sink_wait    <= sink_wait - 1;
        end else if (hold_asks != holds_served) begin
            out_ch.ready <= 1'b0;
            sink_wait    <= LONG_HOLD - 1;
            holds_served <= holds_served + 1;
        end else begin
            sink_gap = quiet ? 0 : pick_gap();
            out_ch.ready <= (sink_gap == 0);
            sink_wait    <= (sink_gap == 0) ? 0 : sink_gap - 1;
        end
    end

    // Offer one control tick; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_tick(input logic en, input logic go, input logic [31:0] aim,
                             input logic [15:0] vcmd);
        int       idle;
        t_in_item beat;
        beat.enable             = en;
        beat.start_req          = go;
        beat.target_position    = aim;
        beat.commanded_velocity = vcmd;
        idle = quiet ? 0 : pick_gap();
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result beat has arrived.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (ticks_seen != ticks_sent) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the whole register file; only called while the block is idle.
    task automatic configure(input logic mode, input int step, input int ashift,
                             input int lim, input int vshift);
        write_reg(CFG_PROFILE_MODE, 16'(mode));
        write_reg(CFG_ACCEL_STEP, 16'(step));
        write_reg(CFG_ACCEL_SHIFT, 16'(ashift));
        write_reg(CFG_VELOCITY_LIMIT, 16'(lim));
        write_reg(CFG_VELOCITY_SHIFT, 16'(vshift));
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [31:0] goal;
        logic [31:0] base;
        logic [31:0] aim;
        logic [15:0] vcmd;
        logic        en;
        logic        go;
        int          a_units;
        int          step;
        int          ashift;
        int          lim;
        int          vshift;
        int          reach;
        int          span;
        int          len;
        int          phase_no;
        int          random_ticks;

        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        quiet        = 1'b0;
        phase_no     = 0;
        random_ticks = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers at reset: zero step, nothing moves.
        send_tick(1'b1, 1'b0, 32'h7FFF_FFFF, 16'h7FFF);
        send_tick(1'b1, 1'b0, 32'h8000_0000, 16'h8000);
        drain();

        // Jog at the register extremes: full ramps, clamps and disable.
        configure(MODE_JOG, 32767, 16, 32767, 0);
        send_tick(1'b1, 1'b0, 32'h0000_0000, 16'h7FFF);
        send_tick(1'b1, 1'b0, 32'hFFFF_FFFF, 16'h8000);
        send_tick(1'b0, 1'b0, 32'h0000_0000, 16'h0000);
        send_tick(1'b1, 1'b0, 32'h7FFF_FFFF, 16'h8000);
        send_tick(1'b1, 1'b0, 32'h8000_0000, 16'd12345);
        drain();

        // Backward move: start latched while disabled, stuck with zero step.
        configure(MODE_POSITION, 0, 0, 64, 0);
        goal = last_position - 32'd300;
        send_tick(1'b0, 1'b1, goal, 16'h0000);
        send_tick(1'b1, 1'b0, goal, 16'h0000);
        send_tick(1'b1, 1'b0, goal, 16'h0000);
        drain();

        // Jog ticks in the middle of the move share its accumulator.
        configure(MODE_JOG, 4096, 8, 64, 0);
        send_tick(1'b1, 1'b0, goal, 16'd20);
        send_tick(1'b1, 1'b0, goal, 16'd20);
        drain();

        // Resume the move with a real step: ramp, decelerate, snap, clear.
        configure(MODE_POSITION, 4096, 8, 64, 0);
        repeat (14) send_tick(1'b1, 1'b0, goal, 16'h0000);

        // Random phases, each one starting from an idle block.
        while (random_ticks < RANDOM_TICKS) begin
            drain();
            quiet = ($urandom_range(0, 3) == 0);
            if (phase_no % 5 == 0) hold_asks++;

            if ($urandom_range(0, 9) < 6) begin
                // Position phase: short moves sized to finish in a few dozen ticks.
                a_units = $urandom_range(1, 200);
                ashift  = $urandom_range(0, 16);
                step    = ((a_units << 16) + $urandom_range(0, 65535)) >> ashift;
                if (step > 32767) begin
                    ashift = 16;
                    step   = a_units;
                end
                lim    = $urandom_range((a_units > 8) ? a_units : 8, 4 * a_units + 50);
                vshift = $urandom_range(0, 3);
                configure(MODE_POSITION, step, ashift, lim, vshift);
                reach = ((64 * a_units < 16 * lim) ? 64 * a_units : 16 * lim) >>> vshift;
                base  = last_position;
                repeat ($urandom_range(2, 4)) begin
                    span = $urandom_range(0, reach);
                    goal = $urandom_range(0, 1) ? base + span : base - span;
                    for (int k = 0; k < MOVE_TICKS; k++) begin
                        en  = ($urandom_range(0, 9) != 0);
                        go  = (k == 0) || ($urandom_range(0, 19) == 0);
                        aim = goal;
                        if ($urandom_range(0, 9) == 0) begin
                            aim = base - reach + $urandom_range(0, 2 * reach);
                        end
                        send_tick(en, go, aim, 16'($urandom));
                        random_ticks++;
                    end
                    base = goal;
                end
            end else begin
                // Jog phase: commands held for runs of ticks so ramps develop.
                configure(MODE_JOG, pick_field(32767), pick_field(16), pick_field(32767),
                          pick_field(15));
                len  = $urandom_range(15, 40);
                vcmd = 16'($urandom);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 5) == 0) vcmd = 16'($urandom);
                    en = ($urandom_range(0, 9) != 0);
                    go = ($urandom_range(0, 9) == 0);
                    send_tick(en, go, $urandom, vcmd);
                    random_ticks++;
                end
            end
            phase_no++;
        end

        drain();
        repeat (DRAIN_TAIL) @(negedge i_clk);
        wrap_up <= 1'b1;
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// File: trapezoidal_motion_profile.f
design/tmp_pkg.sv
design/tmp_channels.sv
design/tmp_cfg_regs.sv
design/tmp_tick.sv
design/trapezoidal_motion_profile.sv
dv/tmp_checker.sv
dv/tb.sv
